// ----- rtl/local_alignment_traceback_defines.svh -----
// assertion macros used by the checker file
`ifndef LOCAL_ALIGNMENT_TRACEBACK_DEFINES_SVH
`define LOCAL_ALIGNMENT_TRACEBACK_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define LAT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define LAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lat_pkg.sv -----
`default_nettype none

package lat_pkg;

   // fixed field widths of the transaction ports
   localparam int ACTION_W = 3;
   localparam int SYMBOL_W = 8;
   localparam int STATUS_W = 2;
   localparam int SCORE_W  = 9;
   localparam int ROW_W    = 9;
   localparam int COL_W    = 11;
   localparam int COUNT_W  = 11;
   localparam int OP_W     = 2;

   // request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR    = 3'd0,
      ACT_LOAD_Q   = 3'd1,
      ACT_LOAD_R   = 3'd2,
      ACT_RUN      = 3'd3,
      ACT_FETCH    = 3'd4
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_NO_ALIGN = 2'd2,
      STAT_NO_MORE  = 2'd3
   } status_type;

   // traceback direction per grid cell
   typedef enum logic [OP_W-1:0] {
      DIR_DIAG = 2'd0,
      DIR_UP   = 2'd1,
      DIR_LEFT = 2'd2,
      DIR_STOP = 2'd3
   } dir_type;

endpackage

`default_nettype wire

// ----- rtl/lat_cell_unit.sv -----
`default_nettype none

module lat_cell_unit #(
   parameter int SW = 9
) (
   input  logic [SW-1:0]    up,
   input  logic [SW-1:0]    left,
   input  logic [SW-1:0]    diag,
   input  logic             match,
   output logic [SW-1:0]    score,
   output lat_pkg::dir_type dir
);
   import lat_pkg::*;

   logic [SW-1:0] diag_sum;
   logic [SW-1:0] up_gap;
   logic [SW-1:0] left_gap;
   logic [SW-1:0] best;

   // gap candidates saturate at zero, which the floor of the rule covers
   assign diag_sum = diag + SW'(match);
   assign up_gap   = (up != '0) ? up - SW'(1) : '0;
   assign left_gap = (left != '0) ? left - SW'(1) : '0;

   // maximum of the three candidates
   always_comb begin
      best = diag_sum;
      if (up_gap > best) best = up_gap;
      if (left_gap > best) best = left_gap;
   end

   assign score = best;

   // direction: stop on a zero score, else diagonal first, then insertion, then deletion
   always_comb begin
      priority if (best == '0) begin
         dir = DIR_STOP;
      end else if (best == diag_sum) begin
         dir = DIR_DIAG;
      end else if (best == up_gap) begin
         dir = DIR_UP;
      end else begin
         dir = DIR_LEFT;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lat_trace_step.sv -----
`default_nettype none

module lat_trace_step #(
   parameter int QW     = 9,
   parameter int RW     = 11,
   parameter int GA     = 18,
   parameter int STRIDE = 1024
) (
   input  lat_pkg::dir_type dir,
   input  logic [QW-1:0]    row,
   input  logic [RW-1:0]    col,
   input  logic [GA-1:0]    addr,
   output logic [QW-1:0]    row_nxt,
   output logic [RW-1:0]    col_nxt,
   output logic [GA-1:0]    addr_nxt
);
   import lat_pkg::*;

   localparam logic [GA-1:0] UP_STEP   = GA'(STRIDE);
   localparam logic [GA-1:0] DIAG_STEP = GA'(STRIDE + 1);

   logic [GA-1:0] step;

   // walk back one cell in the grid; the row stride is the reference capacity
   always_comb begin
      row_nxt = row;
      col_nxt = col;
      step    = '0;
      unique case (dir)
         DIR_DIAG: begin
            row_nxt = row - QW'(1);
            col_nxt = col - RW'(1);
            step    = DIAG_STEP;
         end
         DIR_UP: begin
            row_nxt = row - QW'(1);
            step    = UP_STEP;
         end
         DIR_LEFT: begin
            col_nxt = col - RW'(1);
            step    = GA'(1);
         end
         default: begin
            step = '0;
         end
      endcase
      addr_nxt = addr - step;
   end

endmodule

`default_nettype wire

// ----- rtl/local_alignment_traceback.sv -----
// Local alignment engine. Every transaction gives exactly one response: rsp_valid is high
// for one cycle and the receiver cannot stall, so it must take each response as it comes.
// Clear, loads, unused actions and a fetch past the end answer in the next cycle with busy
// staying low, so they can be issued every cycle. A fetch of a recorded op reads the op
// buffer into a register and answers from the S_FETCH state. A run scores each grid cell in
// the states S_CELL_RD and S_CELL_CALC through a single cell unit and the single-port row
// score memory, then walks the traceback through the direction memory, reading each op in
// S_TB_RD and recording it in S_TB_STEP; busy is high for all of it. An empty query or
// reference answers a run in the next cycle.
`default_nettype none

module local_alignment_traceback #(
   parameter int MAX_QUERY     = 256,
   parameter int MAX_REFERENCE = 1024,
   parameter int OP_DEPTH      = 1280
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lat_pkg::ACTION_W-1:0]   req_action,
   input  logic [lat_pkg::SYMBOL_W-1:0]   req_symbol,
   output logic                           rsp_valid,
   output logic [lat_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lat_pkg::SCORE_W-1:0]    rsp_best_score,
   output logic [lat_pkg::ROW_W-1:0]      rsp_end_row,
   output logic [lat_pkg::COL_W-1:0]      rsp_end_col,
   output logic [lat_pkg::COL_W-1:0]      rsp_start_col,
   output logic [lat_pkg::COUNT_W-1:0]    rsp_op_count,
   output logic [lat_pkg::OP_W-1:0]       rsp_op_code,
   output logic                           rsp_last_op
);
   import lat_pkg::*;

   localparam int QW = $clog2(MAX_QUERY + 1);
   localparam int QA = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int RW = $clog2(MAX_REFERENCE + 1);
   localparam int RA = (MAX_REFERENCE > 1) ? $clog2(MAX_REFERENCE) : 1;
   localparam int CW = $clog2(MAX_REFERENCE + 2);
   localparam int GD = MAX_QUERY * MAX_REFERENCE;
   localparam int GA = (GD > 1) ? $clog2(GD) : 1;
   localparam int OW = $clog2(OP_DEPTH + 1);
   localparam int OA = $clog2(OP_DEPTH);
   localparam int SW = QW;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_FETCH     = 7'b0000010,
      S_ROW       = 7'b0000100,
      S_CELL_RD   = 7'b0001000,
      S_CELL_CALC = 7'b0010000,
      S_TB_RD     = 7'b0100000,
      S_TB_STEP   = 7'b1000000
   } state_type;

   // memories
   logic [SYMBOL_W-1:0] q_mem    [MAX_QUERY];
   logic [SYMBOL_W-1:0] r_mem    [MAX_REFERENCE];
   logic [SW-1:0]       rs_mem   [MAX_REFERENCE];
   logic [OP_W-1:0]     grid_mem [GD];
   logic [OP_W-1:0]     op_mem   [OP_DEPTH];

   logic [SYMBOL_W-1:0] q_rd_ff, r_rd_ff;
   logic [SW-1:0]       rs_rd_ff;
   logic [OP_W-1:0]     grid_rd_ff, op_rd_ff;

   logic q_we, r_we, rs_we, grid_we, op_we;
   logic q_re, r_re, rs_re, grid_re, op_re;

   // control and datapath registers
   state_type     state_ff, state_in;
   logic [QW-1:0] q_len_ff, q_len_in;
   logic [RW-1:0] r_len_ff, r_len_in;
   logic [QW-1:0] row_ff, row_in;
   logic [RW-1:0] col_ff, col_in;
   logic [GA-1:0] gaddr_ff, gaddr_in;
   logic [GA-1:0] rbase_ff, rbase_in;
   logic [SW-1:0] left_ff, left_in;
   logic [SW-1:0] diag_ff, diag_in;
   logic [SW-1:0] best_ff, best_in;
   logic [QW-1:0] br_ff, br_in;
   logic [RW-1:0] bc_ff, bc_in;
   logic [GA-1:0] baddr_ff, baddr_in;
   logic [OW-1:0] cnt_ff, cnt_in;
   logic [OW-1:0] rdptr_ff, rdptr_in;

   // summary of the last run
   logic [SW-1:0] sum_score_ff, sum_score_in;
   logic [QW-1:0] sum_row_ff, sum_row_in;
   logic [RW-1:0] sum_col_ff, sum_col_in;
   logic [CW-1:0] sum_start_ff, sum_start_in;
   logic [OW-1:0] sum_count_ff, sum_count_in;

   // response registers
   logic            rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OP_W-1:0] rsp_op_ff, rsp_op_in;
   logic            rsp_last_ff, rsp_last_in;

   logic          accept;
   logic [SW-1:0] cell_up;
   logic [SW-1:0] cell_score;
   dir_type       cell_dir;
   logic [QW-1:0] tb_row;
   logic [RW-1:0] tb_col;
   logic [GA-1:0] tb_addr;
   logic [RA-1:0] col_addr;

   assign accept   = start && (state_ff == S_IDLE);
   assign col_addr = RA'(col_ff - RW'(1));

   // shared cell unit, first row sees a zero row above
   assign cell_up = (row_ff == QW'(1)) ? '0 : rs_rd_ff;

   lat_cell_unit #(
      .SW (SW)
   ) u_cell (
      .up    (cell_up),
      .left  (left_ff),
      .diag  (diag_ff),
      .match (q_rd_ff == r_rd_ff),
      .score (cell_score),
      .dir   (cell_dir)
   );

   lat_trace_step #(
      .QW     (QW),
      .RW     (RW),
      .GA     (GA),
      .STRIDE (MAX_REFERENCE)
   ) u_step (
      .dir      (dir_type'(grid_rd_ff)),
      .row      (row_ff),
      .col      (col_ff),
      .addr     (gaddr_ff),
      .row_nxt  (tb_row),
      .col_nxt  (tb_col),
      .addr_nxt (tb_addr)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      q_len_in      = q_len_ff;
      r_len_in      = r_len_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      gaddr_in      = gaddr_ff;
      rbase_in      = rbase_ff;
      left_in       = left_ff;
      diag_in       = diag_ff;
      best_in       = best_ff;
      br_in         = br_ff;
      bc_in         = bc_ff;
      baddr_in      = baddr_ff;
      cnt_in        = cnt_ff;
      rdptr_in      = rdptr_ff;
      sum_score_in  = sum_score_ff;
      sum_row_in    = sum_row_ff;
      sum_col_in    = sum_col_ff;
      sum_start_in  = sum_start_ff;
      sum_count_in  = sum_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_op_in     = '0;
      rsp_last_in   = 1'b0;
      q_we = 1'b0; r_we = 1'b0; rs_we = 1'b0; grid_we = 1'b0; op_we = 1'b0;
      q_re = 1'b0; r_re = 1'b0; rs_re = 1'b0; grid_re = 1'b0; op_re = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_CLEAR: begin
                     q_len_in     = '0;
                     r_len_in     = '0;
                     rdptr_in     = '0;
                     sum_score_in = '0;
                     sum_row_in   = '0;
                     sum_col_in   = '0;
                     sum_start_in = '0;
                     sum_count_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_LOAD_Q: begin
                     rsp_valid_in = 1'b1;
                     if (q_len_ff == QW'(MAX_QUERY)) begin
                        rsp_status_in = STAT_OVERFLOW;
                     end else begin
                        q_we     = 1'b1;
                        q_len_in = q_len_ff + QW'(1);
                     end
                  end
                  ACT_LOAD_R: begin
                     rsp_valid_in = 1'b1;
                     if (r_len_ff == RW'(MAX_REFERENCE)) begin
                        rsp_status_in = STAT_OVERFLOW;
                     end else begin
                        r_we     = 1'b1;
                        r_len_in = r_len_ff + RW'(1);
                     end
                  end
                  ACT_RUN: begin
                     rdptr_in     = '0;
                     sum_score_in = '0;
                     sum_row_in   = '0;
                     sum_col_in   = '0;
                     sum_start_in = '0;
                     sum_count_in = '0;
                     if (q_len_ff == '0 || r_len_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NO_ALIGN;
                     end else begin
                        row_in   = QW'(1);
                        rbase_in = '0;
                        best_in  = '0;
                        br_in    = '0;
                        bc_in    = '0;
                        baddr_in = '0;
                        state_in = S_ROW;
                     end
                  end
                  ACT_FETCH: begin
                     if (rdptr_ff < sum_count_ff) begin
                        op_re    = 1'b1;
                        state_in = S_FETCH;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NO_MORE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // deliver the fetched op
         S_FETCH: begin
            rsp_valid_in = 1'b1;
            rsp_op_in    = op_rd_ff;
            rsp_last_in  = (rdptr_ff + OW'(1) == sum_count_ff);
            rdptr_in     = rdptr_ff + OW'(1);
            state_in     = S_IDLE;
         end

         // fetch query symbol of the row
         S_ROW: begin
            q_re     = 1'b1;
            col_in   = RW'(1);
            gaddr_in = rbase_ff;
            left_in  = '0;
            diag_in  = '0;
            state_in = S_CELL_RD;
         end

         // fetch reference symbol and score above
         S_CELL_RD: begin
            r_re     = 1'b1;
            rs_re    = 1'b1;
            state_in = S_CELL_CALC;
         end

         // score one cell, record direction, track the first best cell
         S_CELL_CALC: begin
            rs_we    = 1'b1;
            grid_we  = 1'b1;
            gaddr_in = gaddr_ff + GA'(1);
            left_in  = cell_score;
            diag_in  = cell_up;
            if (cell_score > best_ff) begin
               best_in  = cell_score;
               br_in    = row_ff;
               bc_in    = col_ff;
               baddr_in = gaddr_ff;
            end
            if (col_ff == r_len_ff) begin
               if (row_ff == q_len_ff) begin
                  if (best_in == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_NO_ALIGN;
                     state_in      = S_IDLE;
                  end else begin
                     row_in   = br_in;
                     col_in   = bc_in;
                     gaddr_in = baddr_in;
                     cnt_in   = '0;
                     state_in = S_TB_RD;
                  end
               end else begin
                  row_in   = row_ff + QW'(1);
                  rbase_in = rbase_ff + GA'(MAX_REFERENCE);
                  state_in = S_ROW;
               end
            end else begin
               col_in   = col_ff + RW'(1);
               state_in = S_CELL_RD;
            end
         end

         // traceback read or finish at the grid border
         S_TB_RD: begin
            if (row_ff == '0 || col_ff == '0) begin
               sum_score_in  = best_ff;
               sum_row_in    = br_ff;
               sum_col_in    = bc_ff;
               sum_start_in  = CW'(col_ff) + CW'(1);
               sum_count_in  = cnt_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               grid_re  = 1'b1;
               state_in = S_TB_STEP;
            end
         end

         // record op and step back, or finish on a zero cell
         S_TB_STEP: begin
            if (dir_type'(grid_rd_ff) == DIR_STOP) begin
               sum_score_in  = best_ff;
               sum_row_in    = br_ff;
               sum_col_in    = bc_ff;
               sum_start_in  = CW'(col_ff) + CW'(1);
               sum_count_in  = cnt_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               if (cnt_ff < OW'(OP_DEPTH)) begin
                  op_we  = 1'b1;
                  cnt_in = cnt_ff + OW'(1);
               end
               row_in   = tb_row;
               col_in   = tb_col;
               gaddr_in = tb_addr;
               state_in = S_TB_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory ports, registered reads
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_len_ff[QA-1:0]] <= req_symbol;
      if (q_re) q_rd_ff <= q_mem[QA'(row_ff - QW'(1))];
   end

   always_ff @(posedge clock) begin
      if (r_we) r_mem[r_len_ff[RA-1:0]] <= req_symbol;
      if (r_re) r_rd_ff <= r_mem[col_addr];
   end

   always_ff @(posedge clock) begin
      if (rs_we) rs_mem[col_addr] <= cell_score;
      if (rs_re) rs_rd_ff <= rs_mem[col_addr];
   end

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[gaddr_ff] <= cell_dir;
      if (grid_re) grid_rd_ff <= grid_mem[gaddr_ff];
   end

   always_ff @(posedge clock) begin
      if (op_we) op_mem[cnt_ff[OA-1:0]] <= grid_rd_ff;
      if (op_re) op_rd_ff <= op_mem[rdptr_ff[OA-1:0]];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         q_len_ff      <= '0;
         r_len_ff      <= '0;
         rdptr_ff      <= '0;
         sum_score_ff  <= '0;
         sum_row_ff    <= '0;
         sum_col_ff    <= '0;
         sum_start_ff  <= '0;
         sum_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         q_len_ff      <= q_len_in;
         r_len_ff      <= r_len_in;
         rdptr_ff      <= rdptr_in;
         sum_score_ff  <= sum_score_in;
         sum_row_ff    <= sum_row_in;
         sum_col_ff    <= sum_col_in;
         sum_start_ff  <= sum_start_in;
         sum_count_ff  <= sum_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      gaddr_ff      <= gaddr_in;
      rbase_ff      <= rbase_in;
      left_ff       <= left_in;
      diag_ff       <= diag_in;
      best_ff       <= best_in;
      br_ff         <= br_in;
      bc_ff         <= bc_in;
      baddr_ff      <= baddr_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_op_ff     <= rsp_op_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // outputs
   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_best_score = SCORE_W'(sum_score_ff);
   assign rsp_end_row    = ROW_W'(sum_row_ff);
   assign rsp_end_col    = COL_W'(sum_col_ff);
   assign rsp_start_col  = COL_W'(sum_start_ff);
   assign rsp_op_count   = COUNT_W'(sum_count_ff);
   assign rsp_op_code    = rsp_op_ff;
   assign rsp_last_op    = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/lat_checker.sv -----
`default_nettype none
`include "local_alignment_traceback_defines.svh"

module lat_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_valid,
   input wire logic [lat_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [lat_pkg::SCORE_W-1:0]  rsp_best_score,
   input wire logic [lat_pkg::ROW_W-1:0]    rsp_end_row,
   input wire logic [lat_pkg::COL_W-1:0]    rsp_end_col,
   input wire logic [lat_pkg::COUNT_W-1:0]  rsp_op_count,
   input wire logic                         rsp_last_op
);
   import lat_pkg::*;

   logic fetch_last;
   logic ok_last;
   logic no_align;
   logic empty_summary;
   logic scored;
   logic end_cell_set;

   // conditions seen on the response ports
   assign fetch_last    = rsp_valid && rsp_last_op;
   assign ok_last       = (rsp_status == STAT_OK) && (rsp_op_count != '0);
   assign no_align      = rsp_valid && (rsp_status == STAT_NO_ALIGN);
   assign empty_summary = (rsp_best_score == '0) && (rsp_op_count == '0);
   assign scored        = rsp_valid && (rsp_best_score != '0);
   assign end_cell_set  = (rsp_end_row != '0) && (rsp_end_col != '0) && (rsp_op_count != '0);

   // every accepted transaction answers next cycle or holds busy
   `LAT_ASSERT_NEXT(a_accept_answered, start && !busy, rsp_valid || busy, "transaction lost")

   // a response always leaves the block ready
   `LAT_ASSERT_NOW(a_strobe_ready, rsp_valid, !busy, "response while busy")

   // last op only on a good fetch of a nonempty traceback
   `LAT_ASSERT_NOW(a_last_op_ok, fetch_last, ok_last, "bad last op")

   // a failed run leaves an empty summary
   `LAT_ASSERT_NOW(a_no_align_empty, no_align, empty_summary, "summary after failed run")

   // a positive score always has an end cell and ops
   `LAT_ASSERT_NOW(a_end_cell, scored, end_cell_set, "score without end cell")

endmodule

bind local_alignment_traceback lat_checker u_lat_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_best_score (rsp_best_score),
   .rsp_end_row    (rsp_end_row),
   .rsp_end_col    (rsp_end_col),
   .rsp_op_count   (rsp_op_count),
   .rsp_last_op    (rsp_last_op)
);

`default_nettype wire
